### hdl/xvbr_pkg.sv
`default_nettype none

package xvbr_pkg;

	// Largest vector, in bytes, that one command may carry.
	localparam int DEF_MAX_VECTOR_BYTES = 32;

	// Command codes of the stream.
	localparam logic [7:0] CMD_XCOMPLETE = 8'h00;
	localparam logic [7:0] CMD_XTDOMASK  = 8'h01;
	localparam logic [7:0] CMD_XSIR      = 8'h02;
	localparam logic [7:0] CMD_XRUNTEST  = 8'h04;
	localparam logic [7:0] CMD_XREPEAT   = 8'h07;
	localparam logic [7:0] CMD_XSDRSIZE  = 8'h08;
	localparam logic [7:0] CMD_XSDRTDO   = 8'h09;
	localparam logic [7:0] CMD_XSDRB     = 8'h0C;
	localparam logic [7:0] CMD_XSDRC     = 8'h0D;
	localparam logic [7:0] CMD_XSDRE     = 8'h0E;
	localparam logic [7:0] CMD_XSTATE    = 8'h12;
	localparam logic [7:0] CMD_XENDIR    = 8'h13;
	localparam logic [7:0] CMD_XENDDR    = 8'h14;

	// Status codes.
	localparam logic [2:0] ST_OK      = 3'd0;
	localparam logic [2:0] ST_DONE    = 3'd1;
	localparam logic [2:0] ST_BADCMD  = 3'd2;
	localparam logic [2:0] ST_BADDATA = 3'd3;
	localparam logic [2:0] ST_BADSIZE = 3'd4;

	// Position inside the current command.
	typedef enum logic [3:0] {
		PH_CMD    = 4'd0,
		PH_VECTOR = 4'd1,
		PH_SIRLEN = 4'd2,
		PH_COPY   = 4'd3,
		PH_DROP1  = 4'd4,
		PH_SIZE   = 4'd5,
		PH_STATE  = 4'd6,
		PH_ENDX   = 4'd7,
		PH_HALT   = 4'd8
	} phase_t;

	// Sequencer that drains the vector store in reverse.
	typedef enum logic [1:0] {
		CT_ACCEPT  = 2'd0,
		CT_DRAIN_RD = 2'd1,
		CT_DRAIN_LD = 2'd2
	} ctl_t;

endpackage

`default_nettype wire

### hdl/xsvf_vector_byte_reverser.sv
`default_nettype none

// Channel   Dir  Handshake                    Payload
// s_axis    in   s_axis_tvalid/s_axis_tready  tdata[7:0] in_byte
// m_axis    out  m_axis_tvalid/m_axis_tready  tdata out_byte, status, widest_vector_bytes;
//                                             tlast run_last; tuser out_valid
//
// A byte that is copied, dropped or rejected gives its one result in the cycle after it is
// taken, and the next byte can be taken in that same cycle if the result leaves at once.
// The final byte of a vector is sent straight away; the remaining N-1 stored bytes then come
// out through the registered store read port and the output register, one read and one load
// per byte, and the next input byte is taken only once the last of them has been loaded.
// Reset puts the parser at a command boundary with status ok; the store is not cleared.
// A stalled output holds its result, and input is held off until that result is taken.
module xsvf_vector_byte_reverser #(
	parameter int MAX_VECTOR_BYTES = xvbr_pkg::DEF_MAX_VECTOR_BYTES
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_axis_tvalid,
	output logic             s_axis_tready,
	input  wire logic [7:0]  s_axis_tdata,   // [7:0] in_byte
	output logic             m_axis_tvalid,
	input  wire logic        m_axis_tready,
	output logic [23:0]      m_axis_tdata,   // [7:0] out_byte, [10:8] status,
	                                         // [16:11] widest_vector_bytes, [23:17] zero
	output logic             m_axis_tlast,   // run_last
	output logic [0:0]       m_axis_tuser    // [0] out_valid
);

	// The store holds two vectors of XSDRTDO back to back.
	localparam int DEPTH = 2 * MAX_VECTOR_BYTES;
	localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW    = $clog2(DEPTH + 1);
	// The pending counter also counts the four bytes of XRUNTEST and XSDRSIZE.
	localparam int PW    = (CW > 3) ? CW : 3;

	// Parser state.
	xvbr_pkg::phase_t phase_q, phase_d;
	logic [15:0]      vbits_q, vbits_d;
	logic [PW-1:0]    pend_q, pend_d;
	logic [CW-1:0]    fill_q, fill_d;
	logic [5:0]       widest_q, widest_d;
	logic [2:0]       status_q, status_d;

	// Drain sequencer.
	xvbr_pkg::ctl_t   ctl_q, ctl_d;
	logic [AW-1:0]    rd_ptr_q;

	// Vector store, one write port and one registered read port.
	logic [7:0]       store_mem [DEPTH];
	logic [7:0]       rd_data_q;

	// Output register.
	logic             m_valid_q;
	logic [7:0]       obyte_q;
	logic             ovalid_q;
	logic             olast_q;

	logic             in_acc;
	logic             out_free;
	logic             emit;
	logic [7:0]       ebyte;
	logic             drain_start;
	logic             store_wr;
	logic [13:0]      nb;
	logic [5:0]       sir_len;
	logic [PW-1:0]    vec_len;
	logic [PW-1:0]    pend_dec;

	assign out_free      = !m_valid_q || m_axis_tready;
	assign s_axis_tready = (ctl_q == xvbr_pkg::CT_ACCEPT) && out_free;
	assign in_acc        = s_axis_tvalid && s_axis_tready;

	// Byte length of the current XSDRSIZE vector, and of an XSIR length byte.
	assign nb       = {1'b0, vbits_q[15:3]} + {13'd0, |vbits_q[2:0]};
	assign sir_len  = {1'b0, s_axis_tdata[7:3]} + {5'd0, |s_axis_tdata[2:0]};
	assign pend_dec = pend_q - PW'(1);

	// Next parser state for the byte on the input; applied only when it is accepted.
	always_comb begin
		phase_d     = phase_q;
		vbits_d     = vbits_q;
		pend_d      = pend_q;
		fill_d      = fill_q;
		widest_d    = widest_q;
		status_d    = status_q;
		emit        = 1'b0;
		ebyte       = 8'd0;
		drain_start = 1'b0;
		store_wr    = 1'b0;
		vec_len     = '0;
		case (phase_q)
			xvbr_pkg::PH_CMD: begin
				case (s_axis_tdata)
					xvbr_pkg::CMD_XCOMPLETE: begin
						emit     = 1'b1;
						ebyte    = 8'd0;
						status_d = xvbr_pkg::ST_DONE;
						phase_d  = xvbr_pkg::PH_HALT;
					end
					xvbr_pkg::CMD_XTDOMASK, xvbr_pkg::CMD_XSDRTDO,
					xvbr_pkg::CMD_XSDRB, xvbr_pkg::CMD_XSDRC, xvbr_pkg::CMD_XSDRE: begin
						if (nb > 14'(MAX_VECTOR_BYTES)) begin
							status_d = xvbr_pkg::ST_BADSIZE;
							phase_d  = xvbr_pkg::PH_HALT;
						end else begin
							// Only mask and TDO vectors count toward the widest length.
							if ((s_axis_tdata == xvbr_pkg::CMD_XTDOMASK ||
							     s_axis_tdata == xvbr_pkg::CMD_XSDRTDO) &&
							    (nb > {8'd0, widest_q})) begin
								widest_d = nb[5:0];
							end
							if (s_axis_tdata == xvbr_pkg::CMD_XSDRTDO) begin
								vec_len = {nb[PW-2:0], 1'b0};
							end else begin
								vec_len = nb[PW-1:0];
							end
							emit    = 1'b1;
							ebyte   = s_axis_tdata;
							fill_d  = '0;
							pend_d  = vec_len;
							phase_d = (vec_len == '0) ? xvbr_pkg::PH_CMD
							                          : xvbr_pkg::PH_VECTOR;
						end
					end
					xvbr_pkg::CMD_XSIR: begin
						emit    = 1'b1;
						ebyte   = s_axis_tdata;
						phase_d = xvbr_pkg::PH_SIRLEN;
					end
					xvbr_pkg::CMD_XRUNTEST: begin
						emit    = 1'b1;
						ebyte   = s_axis_tdata;
						pend_d  = PW'(4);
						phase_d = xvbr_pkg::PH_COPY;
					end
					xvbr_pkg::CMD_XREPEAT: begin
						phase_d = xvbr_pkg::PH_DROP1;
					end
					xvbr_pkg::CMD_XSDRSIZE: begin
						emit    = 1'b1;
						ebyte   = s_axis_tdata;
						pend_d  = PW'(4);
						phase_d = xvbr_pkg::PH_SIZE;
					end
					xvbr_pkg::CMD_XSTATE: begin
						emit    = 1'b1;
						ebyte   = s_axis_tdata;
						phase_d = xvbr_pkg::PH_STATE;
					end
					xvbr_pkg::CMD_XENDIR, xvbr_pkg::CMD_XENDDR: begin
						phase_d = xvbr_pkg::PH_ENDX;
					end
					default: begin
						status_d = xvbr_pkg::ST_BADCMD;
						phase_d  = xvbr_pkg::PH_HALT;
					end
				endcase
			end
			xvbr_pkg::PH_VECTOR: begin
				store_wr = 1'b1;
				fill_d   = fill_q + CW'(1);
				pend_d   = pend_dec;
				if (pend_dec == '0) begin
					// The byte just taken is the first one out; the rest come from the store.
					emit        = 1'b1;
					ebyte       = s_axis_tdata;
					drain_start = (fill_q != '0);
					fill_d      = '0;
					phase_d     = xvbr_pkg::PH_CMD;
				end
			end
			xvbr_pkg::PH_SIRLEN: begin
				if (sir_len > 6'(MAX_VECTOR_BYTES)) begin
					status_d = xvbr_pkg::ST_BADSIZE;
					phase_d  = xvbr_pkg::PH_HALT;
				end else begin
					emit    = 1'b1;
					ebyte   = s_axis_tdata;
					fill_d  = '0;
					pend_d  = PW'(sir_len);
					phase_d = (sir_len == 6'd0) ? xvbr_pkg::PH_CMD : xvbr_pkg::PH_VECTOR;
				end
			end
			xvbr_pkg::PH_COPY: begin
				emit   = 1'b1;
				ebyte  = s_axis_tdata;
				pend_d = pend_dec;
				if (pend_dec == '0) begin
					phase_d = xvbr_pkg::PH_CMD;
				end
			end
			xvbr_pkg::PH_DROP1: begin
				phase_d = xvbr_pkg::PH_CMD;
			end
			xvbr_pkg::PH_SIZE: begin
				if (pend_q >= PW'(3)) begin
					// The two high bytes of the 32-bit length must be zero.
					if (s_axis_tdata != 8'd0) begin
						status_d = xvbr_pkg::ST_BADSIZE;
						phase_d  = xvbr_pkg::PH_HALT;
					end else begin
						pend_d = pend_dec;
					end
				end else begin
					emit   = 1'b1;
					ebyte  = s_axis_tdata;
					pend_d = pend_dec;
					if (pend_q == PW'(2)) begin
						vbits_d = {8'd0, s_axis_tdata};
					end else begin
						vbits_d = {vbits_q[7:0], s_axis_tdata};
					end
					if (pend_dec == '0) begin
						phase_d = xvbr_pkg::PH_CMD;
					end
				end
			end
			xvbr_pkg::PH_STATE: begin
				if (s_axis_tdata != 8'd0 && s_axis_tdata != 8'd1) begin
					status_d = xvbr_pkg::ST_BADDATA;
					phase_d  = xvbr_pkg::PH_HALT;
				end else begin
					emit    = 1'b1;
					ebyte   = s_axis_tdata;
					phase_d = xvbr_pkg::PH_CMD;
				end
			end
			xvbr_pkg::PH_ENDX: begin
				if (s_axis_tdata != 8'd0) begin
					status_d = xvbr_pkg::ST_BADDATA;
					phase_d  = xvbr_pkg::PH_HALT;
				end else begin
					phase_d = xvbr_pkg::PH_CMD;
				end
			end
			default: begin
				// Halted: the byte is ignored and gives one empty result.
				phase_d = xvbr_pkg::PH_HALT;
			end
		endcase
	end

	// Drain sequencer next state.
	always_comb begin
		ctl_d = ctl_q;
		case (ctl_q)
			xvbr_pkg::CT_ACCEPT: begin
				if (in_acc && drain_start) begin
					ctl_d = xvbr_pkg::CT_DRAIN_RD;
				end
			end
			xvbr_pkg::CT_DRAIN_RD: begin
				ctl_d = xvbr_pkg::CT_DRAIN_LD;
			end
			xvbr_pkg::CT_DRAIN_LD: begin
				if (out_free) begin
					ctl_d = (rd_ptr_q == '0) ? xvbr_pkg::CT_ACCEPT : xvbr_pkg::CT_DRAIN_RD;
				end
			end
			default: begin
				ctl_d = xvbr_pkg::CT_ACCEPT;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_q <= xvbr_pkg::CT_ACCEPT;
		end else begin
			ctl_q <= ctl_d;
		end
	end

	// Parser registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= xvbr_pkg::PH_CMD;
			vbits_q  <= '0;
			pend_q   <= '0;
			fill_q   <= '0;
			widest_q <= '0;
			status_q <= xvbr_pkg::ST_OK;
		end else if (in_acc) begin
			phase_q  <= phase_d;
			vbits_q  <= vbits_d;
			pend_q   <= pend_d;
			fill_q   <= fill_d;
			widest_q <= widest_d;
			status_q <= status_d;
		end
	end

	// Read pointer walks the store from the entry just below the newest one down to entry zero.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_ptr_q <= '0;
		end else if (in_acc && drain_start) begin
			rd_ptr_q <= AW'(fill_q - CW'(1));
		end else if (ctl_q == xvbr_pkg::CT_DRAIN_LD && out_free && rd_ptr_q != '0) begin
			rd_ptr_q <= rd_ptr_q - AW'(1);
		end
	end

	// Store: no write happens while draining, so reads never meet a write in flight.
	always_ff @(posedge clk) begin
		if (in_acc && store_wr) begin
			store_mem[fill_q[AW-1:0]] <= s_axis_tdata;
		end
		rd_data_q <= store_mem[rd_ptr_q];
	end

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (in_acc) begin
			m_valid_q <= 1'b1;
		end else if (ctl_q == xvbr_pkg::CT_DRAIN_LD && out_free) begin
			m_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			m_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			obyte_q  <= ebyte;
			ovalid_q <= emit;
			olast_q  <= !drain_start;
		end else if (ctl_q == xvbr_pkg::CT_DRAIN_LD && out_free) begin
			obyte_q  <= rd_data_q;
			ovalid_q <= 1'b1;
			olast_q  <= (rd_ptr_q == '0);
		end
	end

	// Status and widest length change only when a new byte is taken, which happens only
	// as the previous result leaves, so the live registers belong to the held result.
	assign m_axis_tvalid = m_valid_q;
	assign m_axis_tdata  = {7'd0, widest_q, status_q, obyte_q};
	assign m_axis_tlast  = olast_q;
	assign m_axis_tuser  = ovalid_q;

endmodule

`default_nettype wire

### dv/tb.sv
`timescale 1ns / 100ps

module tb;

	// Largest vector the block takes, and how long the run may last before
	// the watchdog calls it hung.
	localparam int MAX_BYTES   = xvbr_pkg::DEF_MAX_VECTOR_BYTES;
	localparam int CYCLE_LIMIT = 200000;
	// Length of the deliberate receiver stall, in clock cycles.
	localparam int HOLD_CYCLES = 300;
	// Cycles allowed after the last expected result for stray output to show up.
	localparam int TAIL_CYCLES = 150;

	// One output beat as the block should present it.
	typedef struct {
		logic [7:0] data;
		logic       valid;
		logic       last;
		logic [2:0] status;
		logic [5:0] widest;
	} stream_result_t;

	// Scoreboard: it keeps its own copy of the parser state, turns every
	// accepted input request into the output beats it must cause, and checks
	// the beats that come back in order.
	class reversal_scoreboard;
		xvbr_pkg::phase_t phase;
		logic [4:0]     command;
		logic [15:0]    size_bits;
		logic [6:0]     pending_bytes;
		logic [6:0]     fill;
		logic [7:0]     store [64];
		logic [5:0]     widest;
		logic [2:0]     status;
		stream_result_t awaited [$];
		int             errors;
		int             checked;

		function new();
			phase         = xvbr_pkg::PH_CMD;
			command       = '0;
			size_bits     = '0;
			pending_bytes = '0;
			fill          = '0;
			widest        = '0;
			status        = xvbr_pkg::ST_OK;
			errors        = 0;
			checked       = 0;
		endfunction

		function int vector_len(int bits);
			return (bits + 7) / 8;
		endfunction

		function void halt(logic [2:0] code);
			status = code;
			phase  = xvbr_pkg::PH_HALT;
		endfunction

		function void open_vector(int len);
			fill          = '0;
			pending_bytes = len[6:0];
			phase         = (len == 0) ? xvbr_pkg::PH_CMD : xvbr_pkg::PH_VECTOR;
		endfunction

		function int pending();
			return awaited.size();
		endfunction

		// Works out the beats that one accepted stream byte produces.
		function void note_request(logic [7:0] b);
			logic [7:0]     emitted [$];
			stream_result_t r;
			int             nb;
			int             len;
			int             k;
			nb = vector_len(size_bits);
			case (phase)
				xvbr_pkg::PH_CMD: begin
					command = b[4:0];
					case (b)
						xvbr_pkg::CMD_XCOMPLETE: begin
							emitted.push_back(8'h00);
							halt(xvbr_pkg::ST_DONE);
						end
						xvbr_pkg::CMD_XTDOMASK, xvbr_pkg::CMD_XSDRTDO: begin
							if (nb > MAX_BYTES) begin
								halt(xvbr_pkg::ST_BADSIZE);
							end else begin
								if (nb > widest) widest = nb[5:0];
								emitted.push_back(b);
								open_vector((b == xvbr_pkg::CMD_XSDRTDO) ? 2 * nb : nb);
							end
						end
						xvbr_pkg::CMD_XSDRB, xvbr_pkg::CMD_XSDRC, xvbr_pkg::CMD_XSDRE: begin
							if (nb > MAX_BYTES) begin
								halt(xvbr_pkg::ST_BADSIZE);
							end else begin
								emitted.push_back(b);
								open_vector(nb);
							end
						end
						xvbr_pkg::CMD_XSIR: begin
							emitted.push_back(b);
							phase = xvbr_pkg::PH_SIRLEN;
						end
						xvbr_pkg::CMD_XRUNTEST: begin
							emitted.push_back(b);
							pending_bytes = 7'd4;
							phase = xvbr_pkg::PH_COPY;
						end
						xvbr_pkg::CMD_XREPEAT: begin
							phase = xvbr_pkg::PH_DROP1;
						end
						xvbr_pkg::CMD_XSDRSIZE: begin
							emitted.push_back(b);
							pending_bytes = 7'd4;
							phase = xvbr_pkg::PH_SIZE;
						end
						xvbr_pkg::CMD_XSTATE: begin
							emitted.push_back(b);
							phase = xvbr_pkg::PH_STATE;
						end
						xvbr_pkg::CMD_XENDIR, xvbr_pkg::CMD_XENDDR: begin
							phase = xvbr_pkg::PH_ENDX;
						end
						default: begin
							halt(xvbr_pkg::ST_BADCMD);
						end
					endcase
				end
				xvbr_pkg::PH_VECTOR: begin
					store[fill[5:0]] = b;
					fill          = fill + 7'd1;
					pending_bytes = pending_bytes - 7'd1;
					if (pending_bytes == 7'd0) begin
						// The whole vector is in: send it back last byte first.
						for (k = int'(fill) - 1; k >= 0; k--) emitted.push_back(store[k]);
						fill  = '0;
						phase = xvbr_pkg::PH_CMD;
					end
				end
				xvbr_pkg::PH_SIRLEN: begin
					len = vector_len(b);
					if (len > MAX_BYTES) begin
						halt(xvbr_pkg::ST_BADSIZE);
					end else begin
						emitted.push_back(b);
						open_vector(len);
					end
				end
				xvbr_pkg::PH_COPY: begin
					emitted.push_back(b);
					pending_bytes = pending_bytes - 7'd1;
					if (pending_bytes == 7'd0) phase = xvbr_pkg::PH_CMD;
				end
				xvbr_pkg::PH_DROP1: begin
					phase = xvbr_pkg::PH_CMD;
				end
				xvbr_pkg::PH_SIZE: begin
					// The two high bytes of the length must be zero and are not passed on.
					if (pending_bytes >= 7'd3 && b != 8'h00) begin
						halt(xvbr_pkg::ST_BADSIZE);
					end else begin
						if (pending_bytes == 7'd2) begin
							size_bits = {8'h00, b};
							emitted.push_back(b);
						end else if (pending_bytes == 7'd1) begin
							size_bits = {size_bits[7:0], b};
							emitted.push_back(b);
						end
						pending_bytes = pending_bytes - 7'd1;
						if (pending_bytes == 7'd0) phase = xvbr_pkg::PH_CMD;
					end
				end
				xvbr_pkg::PH_STATE: begin
					if (b != 8'h00 && b != 8'h01) begin
						halt(xvbr_pkg::ST_BADDATA);
					end else begin
						emitted.push_back(b);
						phase = xvbr_pkg::PH_CMD;
					end
				end
				xvbr_pkg::PH_ENDX: begin
					if (b != 8'h00) halt(xvbr_pkg::ST_BADDATA);
					else phase = xvbr_pkg::PH_CMD;
				end
				default: begin
					phase = xvbr_pkg::PH_HALT;
				end
			endcase

			// A byte that emits nothing still answers with one empty beat.
			if (emitted.size() == 0) begin
				r.data   = 8'h00;
				r.valid  = 1'b0;
				r.last   = 1'b1;
				r.status = status;
				r.widest = widest;
				awaited.push_back(r);
			end else begin
				for (k = 0; k < emitted.size(); k++) begin
					r.data   = emitted[k];
					r.valid  = 1'b1;
					r.last   = (k == emitted.size() - 1);
					r.status = status;
					r.widest = widest;
					awaited.push_back(r);
				end
			end
		endfunction

		function void compare_field(string name, int want, int got);
			if (want != got) begin
				errors++;
				$display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h", $time, name, want, got);
			end
		endfunction

		// Checks one accepted output beat against the oldest expectation.
		function void check_result(logic [23:0] tdata, logic tlast, logic [0:0] tuser);
			stream_result_t e;
			if (awaited.size() == 0) begin
				errors++;
				$display("%0t: unexpected result, expected none, actual tdata 0x%06h", $time,
					tdata);
			end else begin
				e = awaited.pop_front();
				checked++;
				compare_field("out_byte", e.data, tdata[7:0]);
				compare_field("status", e.status, tdata[10:8]);
				compare_field("widest_vector_bytes", e.widest, tdata[16:11]);
				compare_field("tdata pad", 0, tdata[23:17]);
				compare_field("run_last", e.last, tlast);
				compare_field("out_valid", e.valid, tuser[0]);
			end
		endfunction
	endclass

	logic        clk           = 1'b0;
	logic        arst_n        = 1'b0;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	logic [7:0]  s_axis_tdata  = 8'h00;
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	logic [23:0] m_axis_tdata;
	logic        m_axis_tlast;
	logic [0:0]  m_axis_tuser;

	reversal_scoreboard sb = new();

	// Knobs shared by the sender, the receiver and the main sequence.
	int    tx_idle_pct = 21;
	int    rx_idle_pct = 63;
	int    hold_token  = 0;
	int    hold_seen   = 0;
	int    hold_left   = 0;
	int    sent_count  = 0;
	int    cmd_count   = 0;
	int    gen_nb      = 0;
	int    cycle_count = 0;
	int    goal;
	string fault_name  = "none";

	xsvf_vector_byte_reverser dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tlast  (m_axis_tlast),
		.m_axis_tuser  (m_axis_tuser)
	);

	always #2 clk = ~clk;

	// Watchdog. A hung handshake or a lost result ends the run here.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("%0t: timeout with %0d results still expected", $time, sb.pending());
			$display("FAIL xsvf_vector_byte_reverser");
			$finish;
		end
	end

	// Receiver. Every beat taken at a rising edge is checked; tready is then
	// chosen for the next cycle. A request from the main sequence starts a
	// long stall that this process counts down on its own.
	always @(posedge clk) begin
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			sb.check_result(m_axis_tdata, m_axis_tlast, m_axis_tuser);
		end
		if (hold_token != hold_seen) begin
			hold_seen = hold_token;
			hold_left = HOLD_CYCLES;
		end
		if (hold_left > 0) begin
			hold_left = hold_left - 1;
			m_axis_tready <= 1'b0;
		end else begin
			m_axis_tready <= ($urandom_range(0, 99) >= rx_idle_pct);
		end
	end

	// Offers one stream byte, with random idle cycles in front of it, and
	// returns at the edge where the request is accepted.
	task automatic send_byte(input logic [7:0] b);
		while ($urandom_range(0, 99) < tx_idle_pct) begin
			s_axis_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= b;
		@(posedge clk);
		while (!s_axis_tready) @(posedge clk);
		sb.note_request(b);
		sent_count++;
	endtask

	task automatic send_data(input int n);
		repeat (n) send_byte(8'($urandom_range(0, 255)));
	endtask

	// XSDRSIZE with the two high bytes zero; remembers the vector length that follows.
	task automatic send_size(input logic [15:0] bits);
		send_byte(xvbr_pkg::CMD_XSDRSIZE);
		send_byte(8'h00);
		send_byte(8'h00);
		send_byte(bits[15:8]);
		send_byte(bits[7:0]);
		gen_nb = (int'(bits) + 7) / 8;
	endtask

	// The sender stops and waits until every expected result has been taken.
	task automatic wait_drained();
		s_axis_tvalid <= 1'b0;
		while (sb.pending() != 0) @(posedge clk);
	endtask

	function automatic logic [7:0] pick_vector_cmd();
		case ($urandom_range(0, 4))
			0:       return xvbr_pkg::CMD_XTDOMASK;
			1:       return xvbr_pkg::CMD_XSDRTDO;
			2:       return xvbr_pkg::CMD_XSDRB;
			3:       return xvbr_pkg::CMD_XSDRC;
			default: return xvbr_pkg::CMD_XSDRE;
		endcase
	endfunction

	function automatic bit is_known_cmd(logic [7:0] c);
		case (c)
			xvbr_pkg::CMD_XCOMPLETE, xvbr_pkg::CMD_XTDOMASK, xvbr_pkg::CMD_XSIR,
			xvbr_pkg::CMD_XRUNTEST, xvbr_pkg::CMD_XREPEAT, xvbr_pkg::CMD_XSDRSIZE,
			xvbr_pkg::CMD_XSDRTDO, xvbr_pkg::CMD_XSDRB, xvbr_pkg::CMD_XSDRC,
			xvbr_pkg::CMD_XSDRE, xvbr_pkg::CMD_XSTATE, xvbr_pkg::CMD_XENDIR,
			xvbr_pkg::CMD_XENDDR: return 1'b1;
			default: return 1'b0;
		endcase
	endfunction

	// One well-formed command with random content. Sizes stay small most of
	// the time, with the largest legal vector now and then.
	task automatic send_random_command();
		int         pick;
		int         r;
		int         len;
		logic [15:0] bits;
		logic [7:0] c;
		pick = $urandom_range(0, 99);
		if (pick < 20) begin
			r = $urandom_range(0, 99);
			if (r < 70) bits = 16'($urandom_range(0, 40));
			else if (r < 88) bits = 16'($urandom_range(0, 8 * MAX_BYTES));
			else bits = 16'($urandom_range(8 * MAX_BYTES - 7, 8 * MAX_BYTES));
			send_size(bits);
		end else if (pick < 60) begin
			c = pick_vector_cmd();
			send_byte(c);
			send_data((c == xvbr_pkg::CMD_XSDRTDO) ? 2 * gen_nb : gen_nb);
		end else if (pick < 70) begin
			len = $urandom_range(0, 255);
			send_byte(xvbr_pkg::CMD_XSIR);
			send_byte(8'(len));
			send_data((len + 7) / 8);
		end else if (pick < 78) begin
			send_byte(xvbr_pkg::CMD_XRUNTEST);
			send_data(4);
		end else if (pick < 84) begin
			send_byte(xvbr_pkg::CMD_XREPEAT);
			send_data(1);
		end else if (pick < 92) begin
			send_byte(xvbr_pkg::CMD_XSTATE);
			send_byte(8'($urandom_range(0, 1)));
		end else begin
			send_byte($urandom_range(0, 1) ? xvbr_pkg::CMD_XENDIR : xvbr_pkg::CMD_XENDDR);
			send_byte(8'h00);
		end
		cmd_count++;
	endtask

	// Any fault or XCOMPLETE stops the parser for good, and reset comes only
	// once, so the run ends with one of them picked at random and a few more
	// bytes that the halted block has to answer with empty beats.
	task automatic send_closing_sequence();
		logic [7:0] c;
		case ($urandom_range(0, 5))
			0: begin
				fault_name = "XCOMPLETE";
				send_byte(xvbr_pkg::CMD_XCOMPLETE);
			end
			1: begin
				fault_name = "unknown command";
				do c = 8'($urandom_range(0, 255)); while (is_known_cmd(c));
				send_byte(c);
			end
			2: begin
				fault_name = "bad XSTATE value";
				send_byte(xvbr_pkg::CMD_XSTATE);
				send_byte(8'($urandom_range(2, 255)));
			end
			3: begin
				fault_name = "nonzero XENDIR/XENDDR";
				send_byte($urandom_range(0, 1) ? xvbr_pkg::CMD_XENDIR : xvbr_pkg::CMD_XENDDR);
				send_byte(8'($urandom_range(1, 255)));
			end
			4: begin
				fault_name = "XSDRSIZE high bytes";
				send_byte(xvbr_pkg::CMD_XSDRSIZE);
				if ($urandom_range(0, 1)) begin
					send_byte(8'($urandom_range(1, 255)));
				end else begin
					send_byte(8'h00);
					send_byte(8'($urandom_range(1, 255)));
				end
			end
			default: begin
				fault_name = "oversized vector";
				send_size(16'($urandom_range(8 * MAX_BYTES + 1, 65535)));
				send_byte(pick_vector_cmd());
			end
		endcase
		cmd_count++;
		send_data(6);
	endtask

	initial begin
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;

		// Directed opening: empty vectors of both kinds, an XSDRTDO pair with
		// the data extremes, a legal XSTATE and the two dropped commands.
		send_size(16'd0);
		send_byte(xvbr_pkg::CMD_XSDRE);
		send_byte(xvbr_pkg::CMD_XSIR);
		send_byte(8'h00);
		send_size(16'd9);
		send_byte(xvbr_pkg::CMD_XSDRTDO);
		send_byte(8'hFF);
		send_byte(8'h00);
		send_byte(8'h5A);
		send_byte(8'hA5);
		send_byte(xvbr_pkg::CMD_XSTATE);
		send_byte(8'h01);
		send_byte(xvbr_pkg::CMD_XENDDR);
		send_byte(8'h00);
		send_byte(xvbr_pkg::CMD_XREPEAT);
		send_byte(8'h20);
		cmd_count += 8;

		// First random phase: sender rarely idles, receiver often does.
		goal = sent_count + 70;
		while (sent_count < goal) send_random_command();
		wait_drained();

		// Second phase with the roles swapped.
		tx_idle_pct = 63;
		rx_idle_pct = 21;
		goal = sent_count + 70;
		while (sent_count < goal) send_random_command();
		wait_drained();

		// Third phase at full rate. The receiver stalls for a long stretch at
		// the start while the sender keeps offering, so the block backs up.
		tx_idle_pct = 0;
		rx_idle_pct = 0;
		hold_token++;
		goal = sent_count + 70;
		while (sent_count < goal) send_random_command();

		send_closing_sequence();
		wait_drained();
		repeat (TAIL_CYCLES) @(posedge clk);

		$display("Covered %0d stream bytes in %0d commands, %0d result beats checked,",
			sent_count, cmd_count, sb.checked);
		$display("three idle patterns with one long output stall, ending on %s.", fault_name);
		if (sb.errors == 0 && sb.pending() == 0) begin
			$display("PASS xsvf_vector_byte_reverser");
		end else begin
			$display("FAIL xsvf_vector_byte_reverser");
		end
		$finish;
	end

endmodule

### filelist.f
hdl/xvbr_pkg.sv
hdl/xsvf_vector_byte_reverser.sv
dv/tb.sv
